>>> src/atv_pkg.sv
// Shared types and constants for the archive table validator.
package atv_pkg;

    localparam logic [20:0] MAX_ENTRIES   = 21'h100000;
    localparam logic [31:0] MIN_FILE_SIZE = 32'd24;

    localparam logic ACT_BEGIN = 1'b0;
    localparam logic ACT_WORD  = 1'b1;

    localparam logic STATUS_VALID   = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INFO,
        ST_DATA,
        ST_COUNT,
        ST_CRC,
        ST_START,
        ST_END
    } scan_state_t;

    typedef struct packed {
        logic        action;
        logic [31:0] word;
        logic [31:0] file_size;
    } item_t;

    typedef struct packed {
        logic        status;
        logic [20:0] entry_count;
    } verdict_t;

    // Table size in bytes for a given entry count: 12 + 12 * count.
    function automatic logic [25:0] table_bytes(input logic [20:0] count);
        logic [21:0] n;
        begin
            n = {1'b0, count} + 22'd1;
            table_bytes = {1'b0, n, 3'b000} + {2'b00, n, 2'b00};
        end
    endfunction

endpackage

>>> src/atv_in_stage.sv
// Input register stage holding one item ahead of the checker.
module atv_in_stage
    import atv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [31:0] word,
    input  logic [31:0] file_size,
    input  logic        take,
    output logic        item_valid,
    output item_t       item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = in_valid || (valid_reg && !take);
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{action: action, word: word, file_size: file_size};
        end
    end

endmodule

>>> src/atv_scan.sv
// Scan FSM and structure rules: one archive word per cycle with fire.
module atv_scan
    import atv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  item_t    item,
    output logic     res_valid,
    output verdict_t res
);

    scan_state_t state_reg;
    scan_state_t state_next;
    logic [20:0] entry_idx_reg;
    logic [20:0] entry_idx_next;
    logic [31:0] total_size_reg;
    logic [31:0] total_size_next;
    logic [31:0] table_end_reg;
    logic [31:0] table_end_next;
    logic [20:0] entry_total_reg;
    logic [20:0] entry_total_next;
    logic [31:0] previous_end_reg;
    logic [31:0] previous_end_next;
    logic [31:0] entry_start_reg;
    logic [31:0] entry_start_next;

    logic [32:0] size_sum;
    logic [25:0] table_len;
    logic        last_entry;

    assign size_sum   = {1'b0, table_end_reg} + {1'b0, item.word};
    assign table_len  = table_bytes(item.word[20:0]);
    assign last_entry = ({1'b0, entry_idx_reg} + 22'd1) >= {1'b0, entry_total_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            entry_idx_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            entry_idx_reg <= entry_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_size_reg   <= total_size_next;
        table_end_reg    <= table_end_next;
        entry_total_reg  <= entry_total_next;
        previous_end_reg <= previous_end_next;
        entry_start_reg  <= entry_start_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        entry_idx_next    = entry_idx_reg;
        total_size_next   = total_size_reg;
        table_end_next    = table_end_reg;
        entry_total_next  = entry_total_reg;
        previous_end_next = previous_end_reg;
        entry_start_next  = entry_start_reg;
        res_valid         = 1'b0;
        res               = '{status: STATUS_INVALID, entry_count: 21'd0};

        if (fire)
        begin
            if (item.action == ACT_BEGIN)
            begin
                total_size_next = item.file_size;
                if (item.file_size < MIN_FILE_SIZE)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_INFO;
                end
            end
            else
            begin
                unique case (state_reg)
                    ST_IDLE:
                    begin
                        state_next = ST_IDLE;
                    end
                    ST_INFO:
                    begin
                        table_end_next = item.word;
                        state_next     = ST_DATA;
                    end
                    ST_DATA:
                    begin
                        if (size_sum != {1'b0, total_size_reg})
                        begin
                            res_valid  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_COUNT;
                        end
                    end
                    ST_COUNT:
                    begin
                        priority if (item.word == 32'd0 ||
                                     item.word > {11'd0, MAX_ENTRIES})
                        begin
                            res_valid  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else if ({6'd0, table_len} != table_end_reg)
                        begin
                            res_valid  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            entry_total_next  = item.word[20:0];
                            previous_end_next = table_end_reg;
                            entry_idx_next    = '0;
                            state_next        = ST_CRC;
                        end
                    end
                    ST_CRC:
                    begin
                        state_next = ST_START;
                    end
                    ST_START:
                    begin
                        priority if (item.word < table_end_reg ||
                                     item.word < previous_end_reg)
                        begin
                            res_valid  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else if (entry_idx_reg == 21'd0 && item.word != table_end_reg)
                        begin
                            res_valid  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            entry_start_next = item.word;
                            state_next       = ST_END;
                        end
                    end
                    ST_END:
                    begin
                        priority if (item.word < entry_start_reg ||
                                     item.word > total_size_reg)
                        begin
                            res_valid  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else if (last_entry)
                        begin
                            previous_end_next = item.word;
                            res_valid         = 1'b1;
                            res               = '{status: STATUS_VALID,
                                                  entry_count: entry_total_reg};
                            state_next        = ST_IDLE;
                        end
                        else
                        begin
                            previous_end_next = item.word;
                            entry_idx_next    = entry_idx_reg + 21'd1;
                            state_next        = ST_CRC;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

>>> src/archive_table_validator_core.sv
// Top level of the archive table validator: input stage, checker, result register.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_ready, action, word, file_size | in
//  result  | out_valid, out_ready, status, entry_count   | out
//
// One item per cycle unless a full result register stalls the checker: an item
// waits in the input register, and the verdict it causes is written to the result
// register at the edge on which the checker takes that item.
// Reset clears the input, scan and result valid state; the block starts idle.
// A full result register that is not taken stalls the checker and then input.
module archive_table_validator_core
    import atv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [31:0] word,
    input  logic [31:0] file_size,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic [20:0] entry_count
);

    logic     take;
    logic     item_valid;
    item_t    item;
    logic     res_valid;
    verdict_t res;

    logic     out_valid_reg;
    logic     out_valid_next;
    verdict_t out_reg;

    assign take = item_valid && (!out_valid_reg || out_ready);

    atv_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .word       (word),
        .file_size  (file_size),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    atv_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (take),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        priority if (take && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign entry_count = out_reg.entry_count;

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_INVALID |-> entry_count == 21'd0)
        else $error("invalid verdict with nonzero count");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_VALID |->
            entry_count != 21'd0 && entry_count <= MAX_ENTRIES)
        else $error("valid verdict with count out of range");

    a_result_when_taken: assert property (@(posedge clk) disable iff (!rst_n)
        take && res_valid |=> out_valid)
        else $error("verdict lost");

    a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !take)
        else $error("checker advanced while result blocked");

endmodule

>>> bench/atv_verdict_monitor.sv
// Checker for the archive table validator: predicts each verdict and compares it.
module atv_verdict_monitor
    import atv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        action,
    input  logic [31:0] word,
    input  logic [31:0] file_size,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        status,
    input  logic [20:0] entry_count,
    output int          mismatches,
    output int          verdicts_due
);

    bit          scanning;
    logic [21:0] word_index;
    logic [31:0] total_size;
    logic [31:0] table_end;
    logic [20:0] entry_total;
    logic [31:0] previous_end;
    logic [31:0] entry_start;

    verdict_t expected_verdicts[$];
    int       fail_total = 0;
    int       due = 0;

    assign mismatches   = fail_total;
    assign verdicts_due = due;

    // Advance the scan by one item; return 1 when the item yields a verdict.
    function automatic bit judge_item(input logic act, input logic [31:0] w,
                                      input logic [31:0] fs, output verdict_t v);
        logic [21:0] idx;
        int unsigned rel;
        int unsigned phase;
        int unsigned entry;
        bit          bad;
        v = '0;
        v.status = STATUS_VALID;
        bad = 1'b0;
        if (act == ACT_BEGIN)
        begin
            word_index = '0;
            total_size = fs;
            if (fs < MIN_FILE_SIZE)
            begin
                scanning = 1'b0;
                v.status = STATUS_INVALID;
                return 1'b1;
            end
            scanning = 1'b1;
            return 1'b0;
        end
        if (!scanning)
            return 1'b0;
        idx = word_index;
        word_index = word_index + 22'd1;
        if (idx == 22'd0)
        begin
            table_end = w;
            return 1'b0;
        end
        else if (idx == 22'd1)
        begin
            bad = ({1'b0, table_end} + {1'b0, w}) != {1'b0, total_size};
        end
        else if (idx == 22'd2)
        begin
            bad = (w == 32'd0) || (w > {11'd0, MAX_ENTRIES}) ||
                  ((64'd12 + 64'(w) * 64'd12) != 64'(table_end));
            if (!bad)
            begin
                entry_total  = w[20:0];
                previous_end = table_end;
            end
        end
        else
        begin
            rel   = 32'(idx) - 3;
            phase = rel % 3;
            entry = rel / 3;
            if (phase == 1)
            begin
                bad = (w < table_end) || (w < previous_end) ||
                      (entry == 0 && w != table_end);
                if (!bad)
                    entry_start = w;
            end
            else if (phase == 2)
            begin
                bad = (w < entry_start) || (w > total_size);
                if (!bad)
                begin
                    previous_end = w;
                    if (entry + 1 >= 32'(entry_total))
                    begin
                        scanning = 1'b0;
                        v.entry_count = entry_total;
                        return 1'b1;
                    end
                end
            end
        end
        if (bad)
        begin
            scanning = 1'b0;
            v.status = STATUS_INVALID;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t predicted;
        verdict_t oldest;
        if (!rst_n)
        begin
            scanning     = 1'b0;
            word_index   = '0;
            total_size   = '0;
            table_end    = '0;
            entry_total  = '0;
            previous_end = '0;
            entry_start  = '0;
            expected_verdicts.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected verdict, status %0d count %0d",
                             $time, status, entry_count);
                    fail_total++;
                end
                else
                begin
                    oldest = expected_verdicts.pop_front();
                    if (status !== oldest.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, oldest.status, status);
                        fail_total++;
                    end
                    if (entry_count !== oldest.entry_count)
                    begin
                        $display("%0t: entry_count expected %0d, got %0d",
                                 $time, oldest.entry_count, entry_count);
                        fail_total++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (judge_item(action, word, file_size, predicted))
                    expected_verdicts.push_back(predicted);
            end
        end
        due = expected_verdicts.size();
    end

endmodule

>>> bench/tb.sv
// Testbench top for the archive table validator: stimulus, handshakes and verdict.
module tb
    import atv_pkg::*;
();

    localparam int STALL_LIMIT = 500;
    localparam int HOLD_CYCLES = 40;
    localparam int ITEM_TARGET = 1700;
    localparam int CALM_AFTER  = 1450;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [31:0] word;
    logic [31:0] file_size;
    logic        out_valid;
    logic        out_ready;
    logic        status;
    logic [20:0] entry_count;

    int mismatches;
    int verdicts_due;
    int sent = 0;
    int quiet_cycles = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    logic [31:0] archive_words[$];
    logic [31:0] archive_size;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    archive_table_validator_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .word        (word),
        .file_size   (file_size),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .entry_count (entry_count)
    );

    atv_verdict_monitor u_verdict_mon (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .word         (word),
        .file_size    (file_size),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .entry_count  (entry_count),
        .mismatches   (mismatches),
        .verdicts_due (verdicts_due)
    );

    // Offer one item at the falling edge and hold it until accepted.
    task automatic put_item(input logic a, input logic [31:0] w, input logic [31:0] fs,
                            input bit counted);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        action    <= a;
        word      <= w;
        file_size <= fs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (counted)
            sent++;
    endtask

    // Lay out a well-formed archive with n entries in archive_words.
    task automatic build_archive(input int unsigned n);
        int unsigned info;
        int unsigned cursor;
        int unsigned s;
        int unsigned e;
        logic [31:0] body[$];
        info = 12 + 12 * n;
        cursor = info;
        for (int unsigned i = 0; i < n; i++)
        begin
            s = cursor;
            if (i != 0 && $urandom_range(0, 3) == 0)
                s = cursor + $urandom_range(1, 40);
            e = s + $urandom_range(0, 64);
            body.push_back($urandom);
            body.push_back(s);
            body.push_back(e);
            cursor = e;
        end
        archive_size = cursor + ($urandom_range(0, 1) ? $urandom_range(0, 16) : 0);
        archive_words.delete();
        archive_words.push_back(info);
        archive_words.push_back(archive_size - info);
        archive_words.push_back(n);
        foreach (body[i])
            archive_words.push_back(body[i]);
    endtask

    task automatic damage_archive();
        int k;
        k = $urandom_range(0, archive_words.size() - 1);
        case ($urandom_range(0, 5))
            0: archive_words[k] = $urandom;
            1: archive_words[k] = archive_words[k] + 32'd1;
            2: archive_words[k] = archive_words[k] - 32'd1;
            3: archive_words[k] = 32'd0;
            4: archive_words[k] = 32'hFFFF_FFFF;
            default: archive_size = archive_size + $urandom_range(0, 1) * 2 - 1;
        endcase
    endtask

    task automatic send_archive(input int len);
        put_item(ACT_BEGIN, $urandom, archive_size, 1'b1);
        for (int i = 0; i < len; i++)
            put_item(ACT_WORD, archive_words[i], $urandom, 1'b1);
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(negedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!calm && rst_n && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int pick;
        int len;
        bit paused;
        paused    = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        action    = ACT_BEGIN;
        word      = '0;
        file_size = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        put_item(ACT_WORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        put_item(ACT_BEGIN, 32'hFFFF_FFFF, 32'd0, 1'b1);
        put_item(ACT_BEGIN, 32'd0, 32'd23, 1'b1);
        // smallest valid archive
        put_item(ACT_BEGIN, 32'd0, 32'd24, 1'b1);
        put_item(ACT_WORD, 32'd24, 32'hFFFF_FFFF, 1'b1);
        put_item(ACT_WORD, 32'd0, 32'd0, 1'b1);
        put_item(ACT_WORD, 32'd1, 32'hFFFF_FFFF, 1'b1);
        put_item(ACT_WORD, 32'hFFFF_FFFF, 32'd0, 1'b1);
        put_item(ACT_WORD, 32'd24, 32'hFFFF_FFFF, 1'b1);
        put_item(ACT_WORD, 32'd24, 32'd0, 1'b1);
        // count above the limit
        put_item(ACT_BEGIN, 32'd0, 32'hFFFF_FFFF, 1'b1);
        put_item(ACT_WORD, 32'hFFFF_FFFF, 32'd0, 1'b1);
        put_item(ACT_WORD, 32'd0, 32'd0, 1'b1);
        put_item(ACT_WORD, 32'h0010_0001, 32'd0, 1'b1);
        // info plus data overflows 32 bits
        put_item(ACT_BEGIN, 32'd0, 32'd24, 1'b1);
        put_item(ACT_WORD, 32'hFFFF_FFFF, 32'd0, 1'b1);
        put_item(ACT_WORD, 32'd25, 32'd0, 1'b1);
        // largest count, then dropped by a new begin
        put_item(ACT_BEGIN, 32'd0, 32'h00C0_000C, 1'b1);
        put_item(ACT_WORD, 32'h00C0_000C, 32'd0, 1'b1);
        put_item(ACT_WORD, 32'd0, 32'd0, 1'b1);
        put_item(ACT_WORD, 32'h0010_0000, 32'd0, 1'b1);
        put_item(ACT_BEGIN, 32'd0, 32'd30, 1'b1);
        put_item(ACT_WORD, 32'd0, 32'd0, 1'b1);
        put_item(ACT_WORD, 32'd30, 32'd0, 1'b1);
        put_item(ACT_WORD, 32'd0, 32'd0, 1'b1);

        // fill the block while the receiver holds off
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            put_item(ACT_BEGIN, $urandom, $urandom_range(0, 23), 1'b1);

        while (sent < ITEM_TARGET)
        begin
            calm = (sent >= CALM_AFTER);
            if (!paused && sent >= 800)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                while (verdicts_due != 0)
                    @(negedge clk);
                repeat (4) @(negedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 87)
            begin
                build_archive(pick < 3 ? $urandom_range(40, 150) : $urandom_range(1, 6));
                len = archive_words.size();
                if (pick >= 62 && pick < 80)
                    damage_archive();
                else if (pick >= 80)
                    len = $urandom_range(0, len - 1);
                send_archive(len);
            end
            else if (pick < 93)
            begin
                put_item(ACT_BEGIN, $urandom, $urandom_range(0, 23), 1'b1);
            end
            else
            begin
                put_item(ACT_BEGIN, $urandom,
                         $urandom_range(0, 1) ? $urandom : $urandom_range(24, 300), 1'b1);
                repeat ($urandom_range(1, 6))
                    put_item(ACT_WORD, $urandom, $urandom, 1'b1);
            end
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3))
                    put_item(ACT_WORD, $urandom, $urandom, 1'b0);
        end

        in_valid <= 1'b0;
        while (verdicts_due != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
